[design/bqb_pkg.sv]
// ----------------------------------------------------------------------------
// bqb_pkg
// Shared types and constants of the Bellman Q backup engine.
// ----------------------------------------------------------------------------
package bqb_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_STATES  = 64;
    localparam int DEF_NUM_ACTIONS = 8;

    // Configuration register indexes and reset values
    localparam int          CFG_AW       = 1;
    localparam int          CFG_DW       = 31;
    localparam logic [CFG_AW-1:0] REG_DISCOUNT = 1'd0;
    localparam logic [CFG_AW-1:0] REG_EPSILON  = 1'd1;
    localparam logic [15:0] DISCOUNT_RST = 16'd58982;
    localparam logic [30:0] EPSILON_RST  = 31'd1;

    // Saturation limits
    localparam logic [22:0] WSUM_MAX  = 23'h7F_FFFF;
    localparam logic [30:0] DIFF_MAX  = 31'h7FFF_FFFF;
    localparam logic [62:0] SUMSQ_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    // One finished state-action group, front to back
    typedef struct packed {
        logic [5:0]         from_state;
        logic [2:0]         act;
        logic signed [63:0] wacc;
        logic [22:0]        wsum;
        logic               sweep_end;
    } grp_t;

    // Back-end status seen by the front end
    typedef struct packed {
        logic clearing;
        logic bank_sel;
        logic sweep_done;
    } bk_status_t;

endpackage

[design/bellman_q_backup_engine.sv]
// A result follows its group's last item through the front-end states MUL1,
// MUL2 and ACC, then the back end's 64-step divider and its SQ and UPD states.
// The front end takes no new item until the last one has left ACC, holds a
// finished group in ACC while the two-entry group queue is full, and after a
// sweep-closing item waits until the back end has swapped the value banks.
// Reset: synchronous, active low; a clearing pass zeroes tables.
// ----------------------------------------------------------------------------
// bellman_q_backup_engine
// Fixed-point Q-value iteration backup: front end accumulates, back end
// divides and updates the tables.
// ----------------------------------------------------------------------------
module bellman_q_backup_engine #(
    parameter int NUM_STATES  = bqb_pkg::DEF_NUM_STATES,
    parameter int NUM_ACTIONS = bqb_pkg::DEF_NUM_ACTIONS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // from_state, act, next_state, weight, reward
    input  logic [63:0]                 s_tdata,
    input  logic                        s_tlast,     // group_end
    input  logic                        s_tuser,     // sweep_end
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_state, out_action, new_q, max_diff, sum_sq_diff
    output logic [135:0]                m_tdata,
    output logic                        m_tlast,     // last_of_sweep
    output logic [1:0]                  m_tuser,     // zero_weight, converged
    input  logic                        cfg_we,
    input  logic [bqb_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [bqb_pkg::CFG_DW-1:0]  cfg_wdata
);

    localparam int VW = $clog2(2 * NUM_STATES);

    logic [15:0]         discount_reg;
    logic [30:0]         epsilon_reg;
    logic [VW-1:0]       vb_rd_addr;
    logic signed [31:0]  vb_rd_data;
    bqb_pkg::bk_status_t status;
    logic                q_push;
    bqb_pkg::grp_t       q_push_data;
    logic                q_pop;
    bqb_pkg::grp_t       q_pop_data;
    logic                q_full;
    logic                q_empty;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            discount_reg <= bqb_pkg::DISCOUNT_RST;
            epsilon_reg  <= bqb_pkg::EPSILON_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                bqb_pkg::REG_DISCOUNT: discount_reg <= cfg_wdata[15:0];
                bqb_pkg::REG_EPSILON:  epsilon_reg  <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    bqb_front #(
        .NUM_STATES (NUM_STATES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .discount    (discount_reg),
        .vb_rd_addr  (vb_rd_addr),
        .vb_rd_data  (vb_rd_data),
        .status      (status),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .q_full      (q_full)
    );

    bqb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    bqb_back #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .epsilon    (epsilon_reg),
        .vb_rd_addr (vb_rd_addr),
        .vb_rd_data (vb_rd_data),
        .status     (status),
        .q_pop_data (q_pop_data),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

[design/bqb_fifo.sv]
// ----------------------------------------------------------------------------
// bqb_fifo
// Two-entry queue of finished groups between front end and back end.
// ----------------------------------------------------------------------------
module bqb_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bqb_pkg::grp_t push_data,
    input  logic          pop,
    output bqb_pkg::grp_t pop_data,
    output logic          full,
    output logic          empty
);

    bqb_pkg::grp_t mem_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !full) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((push && !full) && !(pop && !empty)) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!(push && !full) && (pop && !empty)) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/bqb_front.sv]
// ----------------------------------------------------------------------------
// bqb_front
// Accepts transition items, reads V, multiplies and accumulates per group,
// and hands each finished group to the queue.
// ----------------------------------------------------------------------------
module bqb_front #(
    parameter int NUM_STATES = bqb_pkg::DEF_NUM_STATES,
    localparam int VW = $clog2(2 * NUM_STATES)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [63:0]        s_tdata,
    input  logic               s_tlast,
    input  logic               s_tuser,
    input  logic [15:0]        discount,
    output logic [VW-1:0]      vb_rd_addr,
    input  logic signed [31:0] vb_rd_data,
    input  bqb_pkg::bk_status_t status,
    output logic               q_push,
    output bqb_pkg::grp_t      q_push_data,
    input  logic               q_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL1 = 2'd1;
    localparam logic [1:0] F_MUL2 = 2'd2;
    localparam logic [1:0] F_ACC  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [5:0]         ns_mod [64];
    logic [5:0]         s_reg;
    logic [2:0]         a_reg;
    logic [15:0]        w_reg;
    logic signed [31:0] r_reg;
    logic               gend_reg;
    logic               send_reg;
    logic signed [48:0] p1_reg;
    logic signed [49:0] p2_reg;
    logic signed [32:0] term;
    logic signed [63:0] wacc_reg, wacc_sum;
    logic [22:0]        wsum_reg, wsum_sum;
    logic signed [64:0] wacc_wide;
    logic [23:0]        wsum_wide;
    logic               wait_reg, wait_next;
    logic               accept;

    // Reduce next state modulo the state count
    for (genvar g = 0; g < 64; g++) begin : g_nsmod
        assign ns_mod[g] = 6'(g % NUM_STATES);
    end

    assign s_tready   = (state_reg == F_IDLE) && !status.clearing && !wait_reg;
    assign accept     = s_tvalid && s_tready;
    assign vb_rd_addr = VW'(status.bank_sel) * VW'(NUM_STATES) + VW'(ns_mod[s_tdata[14:9]]);

    // Floor of discount*V by 2^16 plus reward, then weight times that term
    assign term = 33'(r_reg) + 33'(p1_reg >>> 16);

    // Saturating accumulation
    assign wacc_wide = 65'(wacc_reg) + 65'(p2_reg);
    assign wsum_wide = {1'b0, wsum_reg} + 24'(w_reg);
    always_comb begin
        if (wacc_wide[64] != wacc_wide[63]) begin
            wacc_sum = wacc_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            wacc_sum = wacc_wide[63:0];
        end
        wsum_sum = wsum_wide[23] ? bqb_pkg::WSUM_MAX : wsum_wide[22:0];
    end

    assign q_push = (state_reg == F_ACC) && gend_reg && !q_full;
    always_comb begin
        q_push_data.from_state = s_reg;
        q_push_data.act        = a_reg;
        q_push_data.wacc       = wacc_sum;
        q_push_data.wsum       = wsum_sum;
        q_push_data.sweep_end  = send_reg;
    end

    // Sequence one item through the multipliers
    always_comb begin
        state_next = state_reg;
        wait_next  = wait_reg;
        if (status.sweep_done) begin
            wait_next = 1'b0;
        end
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_MUL1;
                end
            end
            F_MUL1: state_next = F_MUL2;
            F_MUL2: state_next = F_ACC;
            F_ACC: begin
                if (!gend_reg) begin
                    state_next = F_IDLE;
                end else if (!q_full) begin
                    state_next = F_IDLE;
                    if (send_reg) begin
                        wait_next = 1'b1;
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            wait_reg  <= 1'b0;
            wacc_reg  <= '0;
            wsum_reg  <= '0;
        end else begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
            if (state_reg == F_ACC) begin
                if (!gend_reg) begin
                    wacc_reg <= wacc_sum;
                    wsum_reg <= wsum_sum;
                end else if (!q_full) begin
                    wacc_reg <= '0;
                    wsum_reg <= '0;
                end
            end
        end
    end

    // Hold item fields and products
    always_ff @(posedge aclk) begin
        if (accept) begin
            s_reg    <= s_tdata[5:0];
            a_reg    <= s_tdata[8:6];
            w_reg    <= s_tdata[30:15];
            r_reg    <= s_tdata[62:31];
            gend_reg <= s_tlast;
            send_reg <= s_tuser;
        end
        if (state_reg == F_MUL1) begin
            p1_reg <= $signed({1'b0, discount}) * vb_rd_data;
        end
        if (state_reg == F_MUL2) begin
            p2_reg <= $signed({1'b0, w_reg}) * term;
        end
    end

endmodule

[design/bqb_back.sv]
// ----------------------------------------------------------------------------
// bqb_back
// Divides each finished group, updates Q store, value banks and sweep
// statistics, and drives the result register.
// ----------------------------------------------------------------------------
module bqb_back #(
    parameter int NUM_STATES  = bqb_pkg::DEF_NUM_STATES,
    parameter int NUM_ACTIONS = bqb_pkg::DEF_NUM_ACTIONS,
    localparam int VW = $clog2(2 * NUM_STATES)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [30:0]        epsilon,
    input  logic [VW-1:0]      vb_rd_addr,
    output logic signed [31:0] vb_rd_data,
    output bqb_pkg::bk_status_t status,
    input  bqb_pkg::grp_t      q_pop_data,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [135:0]       m_tdata,
    output logic               m_tlast,
    output logic [1:0]         m_tuser
);

    localparam int QD     = NUM_STATES * NUM_ACTIONS;
    localparam int VD     = 2 * NUM_STATES;
    localparam int QW     = $clog2(QD);
    localparam int CLR_N  = (QD > VD) ? QD : VD;
    localparam int CW     = $clog2(CLR_N + 1);

    localparam logic [2:0] B_CLR  = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_DIV  = 3'd2;
    localparam logic [2:0] B_SQ   = 3'd3;
    localparam logic [2:0] B_UPD  = 3'd4;

    logic signed [31:0] q_mem [QD];
    logic signed [31:0] v_mem [VD];

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      clr_reg;
    logic               bank_reg;
    logic [5:0]         st_mod [64];
    logic [5:0]         ac_mod [8];
    bqb_pkg::grp_t      grp_reg;
    logic [5:0]         s_red;
    logic [5:0]         a_red;
    logic [QW-1:0]      qi;
    logic [VW-1:0]      vi;
    logic signed [31:0] q_old_reg;
    logic signed [31:0] v_old_reg;
    logic               neg_reg;
    logic [63:0]        dm_reg;
    logic [22:0]        rem_reg;
    logic [23:0]        rem2;
    logic               qbit;
    logic [5:0]         step_reg;
    logic signed [31:0] q_val;
    logic signed [31:0] q_reg;
    logic signed [32:0] d;
    logic [31:0]        ad;
    logic [30:0]        adc_reg;
    logic [63:0]        sq_reg;
    logic [30:0]        max_reg;
    logic [62:0]        sumsq_reg;
    logic [30:0]        max_new;
    logic [64:0]        sumsq_wide;
    logic [62:0]        sumsq_new;
    logic               out_free;
    logic               upd_go;
    logic               valid_reg;
    logic [135:0]       data_reg;
    logic               last_reg;
    logic [1:0]         user_reg;

    for (genvar g = 0; g < 64; g++) begin : g_smod
        assign st_mod[g] = 6'(g % NUM_STATES);
    end
    for (genvar g = 0; g < 8; g++) begin : g_amod
        assign ac_mod[g] = 6'(g % NUM_ACTIONS);
    end

    assign s_red = st_mod[grp_reg.from_state];
    assign a_red = ac_mod[grp_reg.act];
    assign qi    = QW'(s_red) * QW'(NUM_ACTIONS) + QW'(a_red);
    assign vi    = VW'({~bank_reg}) * VW'(NUM_STATES) + VW'(s_red);

    // Memories: registered reads, one write port each
    always_ff @(posedge aclk) begin
        vb_rd_data <= v_mem[vb_rd_addr];
        v_old_reg  <= v_mem[vi];
        q_old_reg  <= q_mem[qi];
        if (state_reg == B_CLR) begin
            if (clr_reg < CW'(QD)) begin
                q_mem[clr_reg[QW-1:0]] <= '0;
            end
            if (clr_reg < CW'(VD)) begin
                v_mem[clr_reg[VW-1:0]] <= '0;
            end
        end else if (upd_go) begin
            q_mem[qi] <= q_reg;
            if (a_red == 6'd0 || q_reg > v_old_reg) begin
                v_mem[vi] <= q_reg;
            end
        end
    end

    assign status.clearing   = (state_reg == B_CLR);
    assign status.bank_sel   = bank_reg;
    assign status.sweep_done = upd_go && grp_reg.sweep_end;

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign out_free = !valid_reg || m_tready;
    assign upd_go   = (state_reg == B_UPD) && out_free;

    // One restoring division step
    assign rem2 = {rem_reg, dm_reg[63]};
    assign qbit = (rem2 >= {1'b0, grp_reg.wsum});

    // Sign, saturate and force zero on an empty weight sum
    always_comb begin
        if (grp_reg.wsum == 23'd0) begin
            q_val = '0;
        end else if (neg_reg) begin
            q_val = (dm_reg > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(dm_reg[31:0]);
        end else begin
            q_val = (dm_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dm_reg[31:0]);
        end
    end
    assign d  = 33'(q_val) - 33'(q_old_reg);
    assign ad = d[32] ? 32'(-d) : d[31:0];

    // Sweep statistics after this group
    assign max_new    = (adc_reg > max_reg) ? adc_reg : max_reg;
    assign sumsq_wide = {2'b0, sumsq_reg} + {1'b0, sq_reg};
    assign sumsq_new  = (sumsq_wide > {2'b0, bqb_pkg::SUMSQ_MAX}) ?
                        bqb_pkg::SUMSQ_MAX : sumsq_wide[62:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLR: begin
                if (clr_reg == CW'(CLR_N - 1)) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!q_empty) begin
                    state_next = B_DIV;
                end
            end
            B_DIV: begin
                if (step_reg == 6'd63) begin
                    state_next = B_SQ;
                end
            end
            B_SQ: state_next = B_UPD;
            B_UPD: begin
                if (out_free) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Control state and sweep statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_CLR;
            clr_reg   <= '0;
            bank_reg  <= 1'b0;
            max_reg   <= '0;
            sumsq_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_CLR) begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (upd_go) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
            if (upd_go) begin
                if (grp_reg.sweep_end) begin
                    bank_reg  <= ~bank_reg;
                    max_reg   <= '0;
                    sumsq_reg <= '0;
                end else begin
                    max_reg   <= max_new;
                    sumsq_reg <= sumsq_new;
                end
            end
        end
    end

    // Division, difference and square datapath
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            grp_reg  <= q_pop_data;
            neg_reg  <= q_pop_data.wacc[63];
            dm_reg   <= q_pop_data.wacc[63] ? 64'(-q_pop_data.wacc) : q_pop_data.wacc;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == B_DIV) begin
            dm_reg   <= {dm_reg[62:0], qbit};
            rem_reg  <= qbit ? 23'(rem2 - {1'b0, grp_reg.wsum}) : rem2[22:0];
            step_reg <= step_reg + 6'd1;
        end
        if (state_reg == B_SQ) begin
            q_reg   <= q_val;
            adc_reg <= ad[31] ? bqb_pkg::DIFF_MAX : ad[30:0];
            sq_reg  <= ad * ad;
        end
        if (upd_go) begin
            data_reg <= {1'b0, sumsq_new, max_new, q_reg, a_red[2:0], s_red};
            last_reg <= grp_reg.sweep_end;
            user_reg <= {grp_reg.sweep_end && (max_new < epsilon),
                         grp_reg.wsum == 23'd0};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

[design/bqb_checker.sv]
// ----------------------------------------------------------------------------
// bqb_checker
// Port-level checks of the Bellman Q backup engine, bound to the top level.
// ----------------------------------------------------------------------------
module bqb_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [135:0]               m_tdata,
    input logic                       m_tlast,
    input logic [1:0]                 m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Report convergence only on a sweep-closing result
    a_conv_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("converged without sweep end");

    // Force Q to zero on an empty weight sum
    a_zero_q: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[40:9] == 32'd0)
        else $error("zero weight with nonzero Q");

    // Drop output and input readiness right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("busy after reset");

endmodule

bind bellman_q_backup_engine bqb_checker u_bqb_checker (.*);

[bench/tb_bellman_q_backup_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bellman_q_backup_engine
// Self-checking bench for the Bellman Q backup engine. Transition items are
// streamed in with random gaps, the result stream is stalled at random, and
// every result is compared field by field against a behavioral model of the
// fixed-point Q backup kept in this bench.
// ----------------------------------------------------------------------------
module tb_bellman_q_backup_engine;

    localparam int NS = 64;
    localparam int NA = 8;

    typedef struct packed {
        logic [5:0]  st;
        logic [2:0]  ac;
        logic [31:0] q;
        logic        zw;
        logic        los;
        logic [30:0] mdiff;
        logic [62:0] ssq;
        logic        conv;
    } backup_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [63:0]    s_tdata;
    logic           s_tlast;
    logic           s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [135:0]   m_tdata;
    logic           m_tlast;
    logic [1:0]     m_tuser;
    logic           cfg_we;
    logic [bqb_pkg::CFG_AW-1:0] cfg_addr;
    logic [bqb_pkg::CFG_DW-1:0] cfg_wdata;

    bellman_q_backup_engine i_dut (.*);

    // Model state
    logic signed [31:0] q_tab [NS*NA];
    logic signed [31:0] v_tab [2*NS];
    logic               bsel;
    logic signed [63:0] wacc;
    logic [22:0]        wsum;
    logic [30:0]        smax;
    logic [62:0]        ssq;
    logic [15:0]        gamma;
    logic [30:0]        eps;

    backup_t expected_q[$];
    int      n_mismatch;
    bit      hold_off;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // Compute the expected backup for one accepted item
    task automatic backup_model(input logic [5:0] s, input logic [2:0] a,
                                input logic [5:0] ns, input logic [15:0] w,
                                input logic signed [31:0] r, input bit ge, input bit se);
        longint p, term, prod, q, d, ad;
        logic [63:0] sq;
        backup_t e;
        int qi, vi;
        p = longint'(gamma) * longint'(v_tab[bsel*NS + ns]);
        term = longint'(r) + (p >>> 16);
        prod = longint'(w) * term;
        if (prod > 0 && wacc > 64'sh7FFF_FFFF_FFFF_FFFF - prod)
            wacc = 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (prod < 0 && wacc < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - prod)
            wacc = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
        else
            wacc = wacc + prod;
        if (longint'(wsum) + longint'(w) > longint'(bqb_pkg::WSUM_MAX))
            wsum = bqb_pkg::WSUM_MAX;
        else
            wsum = wsum + 23'(w);
        if (!ge) return;
        e.zw = (wsum == 0);
        if (e.zw) begin
            q = 0;
        end else begin
            q = wacc / longint'(wsum);
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
        end
        wacc = 0;
        wsum = 0;
        qi = s * NA + a;
        d = q - longint'(q_tab[qi]);
        ad = d < 0 ? -d : d;
        if (ad > longint'(bqb_pkg::DIFF_MAX)) begin
            if (bqb_pkg::DIFF_MAX > smax) smax = bqb_pkg::DIFF_MAX;
        end else if (ad[30:0] > smax) begin
            smax = ad[30:0];
        end
        sq = 64'(ad) * 64'(ad);
        if (sq > 64'(bqb_pkg::SUMSQ_MAX) - 64'(ssq)) ssq = bqb_pkg::SUMSQ_MAX;
        else ssq = ssq + sq[62:0];
        q_tab[qi] = q[31:0];
        vi = (bsel ^ 1'b1) * NS + s;
        if (a == 0 || q > longint'(v_tab[vi])) v_tab[vi] = q[31:0];
        e.st = s;
        e.ac = a;
        e.q = q[31:0];
        e.los = se;
        e.mdiff = smax;
        e.ssq = ssq;
        e.conv = se && (smax < eps);
        expected_q.push_back(e);
        if (se) begin
            bsel = ~bsel;
            smax = 0;
            ssq = 0;
        end
    endtask

    // Send one transition item and update the model on acceptance
    task automatic send_item(input logic [5:0] s, input logic [2:0] a, input logic [5:0] ns,
                             input logic [15:0] w, input logic [31:0] r,
                             input bit ge, input bit se);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {1'b0, r, w, ns, a, s};
        s_tlast  <= ge;
        s_tuser  <= se;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        backup_model(s, a, ns, w, r, ge, se);
        @(negedge aclk);
    endtask

    // Wait for all results, then let the back end settle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [bqb_pkg::CFG_AW-1:0] idx,
                             input logic [bqb_pkg::CFG_DW-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        if (idx == bqb_pkg::REG_DISCOUNT) gamma = val[15:0];
        else if (idx == bqb_pkg::REG_EPSILON) eps = val[30:0];
    endtask

    // One group: n entries for pair (s,a), optionally closing the sweep
    task automatic send_group(input int s, input int a, input int n, input bit se,
                              input bit big);
        for (int i = 0; i < n; i++) begin
            send_item(6'(s), 3'(a), 6'($urandom_range(0, 63)),
                      big ? 16'hFFFF : 16'($urandom_range(0, 65535)),
                      big ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                          : $urandom(), i == n - 1, se && i == n - 1);
        end
    endtask

    task automatic test_directed;
        // Extremes of weight and reward, zero weight group, largest field values
        send_item(0, 0, 0, 16'hFFFF, 32'h7FFF_FFFF, 1, 0);
        send_item(63, 7, 63, 16'hFFFF, 32'h8000_0000, 1, 0);
        send_item(1, 0, 5, 16'h0000, 32'h1234_5678, 0, 0);
        send_item(1, 0, 6, 16'h0000, 32'hFFFF_FFFF, 1, 0);
        send_item(2, 3, 1, 16'h0001, 32'h0001_0000, 0, 1);
        send_item(2, 3, 0, 16'h8000, 32'hFFFF_0000, 1, 0);
        for (int i = 0; i < 8; i++)
            send_item(3, 1, 63, 16'hFFFF, 32'h7FFF_FFFF, i == 7, 0);
        send_item(0, 1, 0, 16'hFFFF, 32'h8000_0000, 1, 0);
        send_item(5, 0, 0, 16'hAAAA, 32'h5555_5555, 1, 1);
        send_item(0, 0, 0, 16'h5555, 32'hAAAA_AAAA, 1, 0);
        send_item(0, 0, 63, 16'hFFFF, 32'h0000_0000, 1, 1);
        drain();
    endtask

    // Full sweeps over a few states, all actions in order
    task automatic test_sweeps(input int n_sweeps, input int n_states);
        int base;
        for (int k = 0; k < n_sweeps; k++) begin
            base = $urandom_range(0, 63 - n_states + 1);
            for (int s = 0; s < n_states; s++)
                for (int a = 0; a < NA; a++)
                    send_group(base + s, a, $urandom_range(1, 4),
                               s == n_states - 1 && a == NA - 1, $urandom_range(0, 15) == 0);
        end
        drain();
    endtask

    // Unstructured items, sparse group and sweep ends
    task automatic test_noise(input int n);
        for (int i = 0; i < n; i++) begin
            send_item(6'($urandom), 3'($urandom), 6'($urandom), 16'($urandom), $urandom,
                      $urandom_range(0, 2) == 0, $urandom_range(0, 5) == 0);
        end
        send_item(0, 0, 0, 0, 0, 1, 1);
        drain();
    endtask

    // Receiver holds off long while sender keeps offering items
    task automatic test_backpressure;
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++)
                send_item(6'(i), 0, 6'(i), 16'hFFFF, $urandom, 1, i == 11);
        join
        drain();
    endtask

    // Result checker
    always @(posedge aclk) begin
        backup_t got, e;
        if (aresetn && m_tvalid && m_tready) begin
            got.st    = m_tdata[5:0];
            got.ac    = m_tdata[8:6];
            got.q     = m_tdata[40:9];
            got.mdiff = m_tdata[71:41];
            got.ssq   = m_tdata[134:72];
            got.los   = m_tlast;
            got.zw    = m_tuser[0];
            got.conv  = m_tuser[1];
            if (expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %p", got);
            end else begin
                e = expected_q.pop_front();
                if (got !== e) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected %p actual %p", e, got);
                end
            end
        end
    end

    // Random receiver stalls
    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                if (gap == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial begin
        #60ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        s_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        hold_off = 1'b0;
        n_mismatch = 0;
        foreach (q_tab[i]) q_tab[i] = 0;
        foreach (v_tab[i]) v_tab[i] = 0;
        bsel = 0;
        wacc = 0;
        wsum = 0;
        smax = 0;
        ssq = 0;
        gamma = bqb_pkg::DISCOUNT_RST;
        eps = bqb_pkg::EPSILON_RST;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        write_reg(bqb_pkg::REG_DISCOUNT, 31'h0000_FFFF);
        write_reg(bqb_pkg::REG_EPSILON, 31'h7FFF_FFFF);
        test_sweeps(2, 3);
        write_reg(bqb_pkg::REG_DISCOUNT, 31'h0000_0000);
        write_reg(bqb_pkg::REG_EPSILON, 31'h0000_0000);
        test_sweeps(2, 3);
        write_reg(bqb_pkg::REG_DISCOUNT, bqb_pkg::CFG_DW'($urandom_range(0, 65535)));
        write_reg(bqb_pkg::REG_EPSILON, bqb_pkg::CFG_DW'($urandom_range(0, 32'h0004_0000)));
        test_backpressure();
        test_sweeps(6, 3);
        write_reg(bqb_pkg::REG_DISCOUNT, bqb_pkg::CFG_DW'(bqb_pkg::DISCOUNT_RST));
        write_reg(bqb_pkg::REG_EPSILON, 31'h0000_0100);
        test_noise(250);
        test_sweeps(3, 2);

        if (n_mismatch == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
